>>> sv/spr_pkg.sv
// Package for the smallest primitive root block: sequencer states and the
// control struct passed to the shared divide unit. No dependencies.
`default_nettype none
package spr_pkg;
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRIME_DIV,
      ST_PRIME_CHK,
      ST_FAC_INIT,
      ST_FAC_DIV,
      ST_FAC_CHK,
      ST_CAND,
      ST_EXP_DIV,
      ST_POW_STEP,
      ST_POW_MUL,
      ST_POW_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;
endpackage
`default_nettype wire

>>> sv/smallest_primitive_root.sv
// Smallest primitive root modulo a prime: one request in, one response out.
// Latency is data dependent: the shared divider is used for trial division,
// factoring and every modular multiply.
// busy stays high from start until rsp_valid; one request at a time.
// Synchronous active-high reset returns to idle; the receiver cannot stall.
// Depends on spr_pkg and spr_divider.
`default_nettype none
module smallest_primitive_root #(
   parameter int WIDTH       = 16,
   parameter int MAX_FACTORS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_number,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [15:0]      rsp_root
);
   import spr_pkg::*;
   localparam int DW = 2 * WIDTH;
   localparam int FW = $clog2(MAX_FACTORS + 1);
   localparam int FI = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in, phi_ff, phi_in, v_ff, v_in, d_ff, d_in;
   logic [WIDTH-1:0] cand_ff, cand_in, acc_ff, acc_in, base_ff, base_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] fac_ff [MAX_FACTORS];
   logic [FW-1:0]    fcnt_ff, fcnt_in, k_ff, k_in;
   logic             sub_ff, sub_in;   // prime test: 0 -> d, 1 -> d+2
   logic             mul_ff, mul_in;   // pow: 0 -> acc*base, 1 -> base*base
   logic             fwr, fdup;
   logic [WIDTH-1:0] fwr_val;
   logic             found_ff, found_in, valid_ff, valid_in;
   logic [15:0]      root_ff, root_in;

   div_ctl_type      dctl;
   logic [DW-1:0]    dividend, divisor, quo, rem;
   logic             ddone;
   logic [DW-1:0]    dsq;

   spr_divider #(.DW(DW)) u_div (
      .clock(clock), .reset(reset), .ctl(dctl), .dividend(dividend),
      .divisor(divisor), .done(ddone), .quotient(quo), .remainder(rem)
   );

   assign dsq = DW'(d_ff) * DW'(d_ff);

   // duplicate check over the factor list
   always_comb begin
      fdup = 1'b0;
      for (int i = 0; i < MAX_FACTORS; i++)
         if (FW'(i) < fcnt_ff && fac_ff[i] == fwr_val) fdup = 1'b1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; phi_in = phi_ff; v_in = v_ff; d_in = d_ff;
      cand_in = cand_ff; acc_in = acc_ff; base_in = base_ff; exp_in = exp_ff;
      fcnt_in = fcnt_ff; k_in = k_ff; sub_in = sub_ff; mul_in = mul_ff;
      found_in = found_ff; root_in = root_ff; valid_in = 1'b0;
      dctl.start = 1'b0; dividend = '0; divisor = '1;
      fwr = 1'b0; fwr_val = d_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = req_number[WIDTH-1:0];
               found_in = 1'b0; root_in = '0;
               if (req_number[WIDTH-1:0] <= WIDTH'(1)) state_in = ST_DONE;
               else if (req_number[WIDTH-1:0] <= WIDTH'(3)) state_in = ST_FAC_INIT;
               else begin
                  d_in = WIDTH'(2); sub_in = 1'b0; state_in = ST_PRIME_CHK;
               end
            end
         end
         ST_PRIME_CHK: begin
            // d is 2, 3, then 6k-1 / 6k+1; exit when d*d > n (for 6k-1)
            if (d_ff >= WIDTH'(5) && !sub_ff && dsq > DW'(n_ff)) begin
               state_in = ST_FAC_INIT;
            end else begin
               dctl.start = 1'b1;
               dividend = DW'(n_ff);
               divisor = DW'(d_ff);
               state_in = ST_PRIME_DIV;
            end
         end
         ST_PRIME_DIV: begin
            dividend = DW'(n_ff);
            divisor = DW'(d_ff);
            if (ddone) begin
               if (rem == '0) state_in = ST_DONE;
               else begin
                  state_in = ST_PRIME_CHK;
                  if (d_ff == WIDTH'(2)) d_in = WIDTH'(3);
                  else if (d_ff == WIDTH'(3)) begin
                     d_in = WIDTH'(5); sub_in = 1'b0;
                  end else if (!sub_ff) begin
                     d_in = d_ff + WIDTH'(2); sub_in = 1'b1;
                  end else begin
                     d_in = d_ff + WIDTH'(4); sub_in = 1'b0;
                  end
               end
            end
         end
         ST_FAC_INIT: begin
            phi_in = n_ff - WIDTH'(1);
            v_in = n_ff - WIDTH'(1);
            d_in = WIDTH'(2);
            fcnt_in = '0;
            state_in = ST_FAC_CHK;
         end
         ST_FAC_CHK: begin
            if (d_ff != WIDTH'(2) && dsq > DW'(v_ff)) begin
               if (v_ff > WIDTH'(2)) begin
                  fwr_val = v_ff;
                  fwr = 1'b1;
               end
               cand_in = WIDTH'(2);
               state_in = ST_CAND;
            end else if (v_ff == '0) begin
               d_in = WIDTH'(3);
            end else begin
               dctl.start = 1'b1;
               dividend = DW'(v_ff);
               divisor = DW'(d_ff);
               state_in = ST_FAC_DIV;
            end
         end
         ST_FAC_DIV: begin
            dividend = DW'(v_ff);
            divisor = DW'(d_ff);
            if (ddone) begin
               state_in = ST_FAC_CHK;
               if (rem == '0) begin
                  v_in = quo[WIDTH-1:0];
                  fwr = 1'b1;
               end else begin
                  d_in = (d_ff == WIDTH'(2)) ? WIDTH'(3) : d_ff + WIDTH'(2);
               end
            end
         end
         ST_CAND: begin
            if (cand_ff > phi_ff || cand_ff == '0) state_in = ST_DONE;
            else begin
               k_in = '0;
               state_in = ST_POW_CHK;
            end
         end
         ST_POW_CHK: begin
            // next factor or accept candidate
            if (k_ff >= fcnt_ff) begin
               found_in = 1'b1;
               root_in = 16'(cand_ff);
               state_in = ST_DONE;
            end else begin
               dctl.start = 1'b1;
               dividend = DW'(phi_ff);
               divisor = DW'(fac_ff[k_ff[FI-1:0]]);
               state_in = ST_EXP_DIV;
            end
         end
         ST_EXP_DIV: begin
            dividend = DW'(phi_ff);
            divisor = DW'(fac_ff[k_ff[FI-1:0]]);
            if (ddone) begin
               exp_in = quo[WIDTH-1:0];
               acc_in = WIDTH'(1);
               base_in = cand_ff;
               state_in = ST_POW_STEP;
            end
         end
         ST_POW_STEP: begin
            if (exp_ff == '0) begin
               if (acc_ff == WIDTH'(1)) begin
                  cand_in = cand_ff + WIDTH'(1);
                  state_in = ST_CAND;
               end else begin
                  k_in = k_ff + FW'(1);
                  state_in = ST_POW_CHK;
               end
            end else begin
               mul_in = !exp_ff[0];
               dctl.start = 1'b1;
               dividend = exp_ff[0] ? DW'(acc_ff) * DW'(base_ff)
                                    : DW'(base_ff) * DW'(base_ff);
               divisor = DW'(n_ff);
               state_in = ST_POW_MUL;
            end
         end
         ST_POW_MUL: begin
            divisor = DW'(n_ff);
            if (ddone) begin
               if (!mul_ff) begin
                  acc_in = rem[WIDTH-1:0];
                  mul_in = 1'b1;
                  dctl.start = 1'b1;
                  dividend = DW'(base_ff) * DW'(base_ff);
               end else begin
                  base_in = rem[WIDTH-1:0];
                  exp_in = exp_ff >> 1;
                  state_in = ST_POW_STEP;
               end
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (fwr && !fdup && fcnt_ff < FW'(MAX_FACTORS)) fcnt_in = fcnt_ff + FW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fcnt_ff  <= fcnt_in;
      end
      n_ff <= n_in; phi_ff <= phi_in; v_ff <= v_in; d_ff <= d_in;
      cand_ff <= cand_in; acc_ff <= acc_in; base_ff <= base_in;
      exp_ff <= exp_in; k_ff <= k_in; sub_ff <= sub_in; mul_ff <= mul_in;
      found_ff <= found_in; root_ff <= root_in;
      if (fwr && !fdup && fcnt_ff < FW'(MAX_FACTORS))
         fac_ff[fcnt_ff[FI-1:0]] <= fwr_val;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_found = found_ff;
   assign rsp_root  = root_ff;

`ifndef ASSERT_OFF
   a_valid_one_cycle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff) else $error("response strobe held");
   a_root_zero_if_not_found: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !found_ff) |-> (root_ff == '0)) else $error("root without found");
   a_fcnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FW'(MAX_FACTORS)) else $error("factor count overflow");
   a_valid_to_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == ST_IDLE) else $error("response while busy");
`endif
endmodule
`default_nettype wire

>>> sv/spr_divider.sv
// Shared restoring divider (one quotient bit per cycle) for the smallest
// primitive root block. Depends on spr_pkg.
`default_nettype none
module spr_divider #(
   parameter int DW = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spr_pkg::div_ctl_type ctl,
   input  wire logic [DW-1:0]     dividend,
   input  wire logic [DW-1:0]     divisor,
   output logic                   done,
   output logic [DW-1:0]          quotient,
   output logic [DW-1:0]          remainder
);
   import spr_pkg::*;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DW-1]} - {1'b0, dsr_ff};
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DW]) begin
            rem_in = {rem_ff[DW-2:0], quo_ff[DW-1]};
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done and busy together");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0)) else $error("divider count underflow");
`endif
endmodule
`default_nettype wire

>>> verif/tb_smallest_primitive_root.sv
// Testbench for smallest_primitive_root: directed and random moduli, each response
// checked against a behavioral search for the smallest primitive root.
// Depends on the RTL top smallest_primitive_root (and through it spr_pkg).
`timescale 1ns / 1ps
module tb_smallest_primitive_root;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [15:0] req_number = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_found;
   logic [15:0] rsp_root;

   typedef struct {
      logic        found;
      logic [15:0] root;
   } root_result_type;

   logic [15:0]     pending_numbers[$];
   root_result_type expected_roots[$];
   int              error_count = 0;
   int              gap_left = 0;
   bit              took;

   smallest_primitive_root u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_found  (rsp_found),
      .rsp_root   (rsp_root)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // trial division over 2, 3 and 6k +/- 1
   function automatic bit is_prime16(longint n);
      longint d;
      if (n <= 1) return 0;
      if (n <= 3) return 1;
      if (n % 2 == 0 || n % 3 == 0) return 0;
      for (d = 5; d * d <= n; d += 6) begin
         if (n % d == 0 || n % (d + 2) == 0) return 0;
      end
      return 1;
   endfunction

   function automatic longint pow_mod(longint b, longint e, longint m);
      longint acc;
      acc = 1 % m;
      b = b % m;
      while (e > 0) begin
         if (e[0]) acc = (acc * b) % m;
         e = e >> 1;
         b = (b * b) % m;
      end
      return acc;
   endfunction

   // smallest r whose order mod n is n-1; none for non-primes and n = 2
   function automatic root_result_type smallest_root(logic [15:0] number);
      root_result_type res;
      longint          n, phi, v, d, r;
      longint          primes[$];
      bit              rejected;
      res.found = 1'b0;
      res.root  = '0;
      n = number;
      if (!is_prime16(n)) return res;
      phi = n - 1;
      v = phi;
      if (v % 2 == 0) primes.push_back(2);
      while (v > 0 && v % 2 == 0) v = v / 2;
      for (d = 3; d * d <= v; d += 2) begin
         if (v % d == 0) primes.push_back(d);
         while (v % d == 0) v = v / d;
      end
      if (v > 2) primes.push_back(v);
      for (r = 2; r <= phi; r++) begin
         rejected = 0;
         foreach (primes[k]) begin
            if (pow_mod(r, phi / primes[k], n) == 1) begin
               rejected = 1;
               break;
            end
         end
         if (!rejected) begin
            res.found = 1'b1;
            res.root  = r[15:0];
            return res;
         end
      end
      return res;
   endfunction

   // random modulus: mostly small, often prime, sometimes full range
   function automatic logic [15:0] random_number();
      logic [15:0] n;
      if ($urandom_range(0, 4) == 0) n = 16'($urandom_range(0, 65535));
      else n = 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 2) != 0) begin
         while (!is_prime16(n) && n < 16'hFFF0) n = n + 16'd1;
      end
      return n;
   endfunction

   // stimulus: directed corners, then random moduli
   initial begin
      logic [15:0] directed[$];
      directed = {16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd11,
                  16'd13, 16'd17, 16'd23, 16'd25, 16'd41, 16'd71, 16'd191, 16'd409,
                  16'd65521, 16'd65519, 16'd65535, 16'd32768, 16'd43691, 16'd32749,
                  16'd21845};
      foreach (directed[i]) pending_numbers.push_back(directed[i]);
      repeat (76) pending_numbers.push_back(random_number());
   end

   // request driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !took) begin
            // hold the request until the block takes it
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_numbers.size() > 0) begin
            req_number <= pending_numbers.pop_front();
            start      <= 1'b1;
            gap_left   <= $urandom_range(0, 13);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: record accepted requests, check responses
   always @(posedge clock) begin
      root_result_type want;
      took = 0;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: response with none expected: found=%0d root=%0d",
                        $time, rsp_found, rsp_root);
               error_count++;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found mismatch: expected %0d actual %0d",
                           $time, want.found, rsp_found);
                  error_count++;
               end
               if (rsp_root !== want.root) begin
                  $display("%0t: root mismatch: expected %0d actual %0d",
                           $time, want.root, rsp_root);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            took = 1;
            expected_roots.push_back(smallest_root(req_number));
         end
      end
   end

   // reset, drain, final verdict
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // poll on clock edges so the driver's pending pop and start update settle
      do begin
         @(posedge clock);
      end while (pending_numbers.size() != 0 || start || expected_roots.size() != 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
sv/spr_pkg.sv
sv/spr_divider.sv
sv/smallest_primitive_root.sv
verif/tb_smallest_primitive_root.sv
